>>> hdl/psu_pkg.sv
package psu_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] RegRowBytes      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegBytesPerPixel = CfgIdxW'(1);

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } psu_filter_e;

  localparam logic [7:0] MaxFilterCode = 8'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
  } psu_in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       end_of_row;
    logic       bad_filter;
  } psu_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } psu_cfg_t;

  typedef struct packed {
    psu_filter_e filter;
    logic [7:0]  left;
    logic [7:0]  up;
    logic [7:0]  upleft;
  } psu_pred_req_t;

endpackage

>>> hdl/psu_stream_if.sv
interface psu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/psu_predict.sv
module psu_predict (
  input  psu_pkg::psu_pred_req_t req_i,
  output logic [7:0]             pred_o
);

  logic [8:0]        avg_sum;
  logic signed [9:0] pa_s, pb_s, pc_s;
  logic [9:0]        pa, pb, pc;
  logic [7:0]        paeth;

  always_comb begin
    avg_sum = {1'b0, req_i.left} + {1'b0, req_i.up};
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    pa_s = $signed({2'b00, req_i.up}) - $signed({2'b00, req_i.upleft});
    pb_s = $signed({2'b00, req_i.left}) - $signed({2'b00, req_i.upleft});
    pc_s = $signed({2'b00, req_i.left}) + $signed({2'b00, req_i.up})
         - $signed({1'b0, req_i.upleft, 1'b0});
    pa = pa_s[9] ? 10'(-pa_s) : 10'(pa_s);
    pb = pb_s[9] ? 10'(-pb_s) : 10'(pb_s);
    pc = pc_s[9] ? 10'(-pc_s) : 10'(pc_s);
    priority if (pa <= pb && pa <= pc) begin
      paeth = req_i.left;
    end else if (pb <= pc) begin
      paeth = req_i.up;
    end else begin
      paeth = req_i.upleft;
    end
    unique case (req_i.filter)
      psu_pkg::FILT_NONE:  pred_o = 8'd0;
      psu_pkg::FILT_SUB:   pred_o = req_i.left;
      psu_pkg::FILT_UP:    pred_o = req_i.up;
      psu_pkg::FILT_AVG:   pred_o = avg_sum[8:1];
      psu_pkg::FILT_PAETH: pred_o = paeth;
      default:             pred_o = 8'd0;
    endcase
  end

endmodule

>>> hdl/png_scanline_unfilter_top.sv
// Channel  Dir  Payload                                  Transfer
// in_i     in   data_byte[8], start_of_image[1]          valid & ready
// out_o    out  pixel_byte[8], end_of_row[1], bad_filter  valid & ready
// cfg_i    in   index[4], data[14]                       valid & ready (ready held high)
//
// One byte per cycle sustained unless out_o stalls; each data byte is registered in the
// stage, then in the output register. Its prior-row read is issued at input transfer,
// then a stage of predictor logic feeds the output register. Filter bytes give no output.
// Reset clears control state; the prior-row memory is not cleared.
// An output stall backs up through one held stage before in_i.ready drops.
module png_scanline_unfilter_top #(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  psu_stream_if.sink          in_i,
  psu_stream_if.source        out_o,
  psu_stream_if.sink          cfg_i
);

  localparam int unsigned CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned PW = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int unsigned HW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  typedef struct packed {
    logic                 is_filter;
    logic [7:0]           data_byte;
    logic [AW-1:0]        x;
    logic                 left_ok;
    logic                 first_row;
    psu_pkg::psu_filter_e filter;
    logic                 bad;
    logic                 last;
  } item_t;

  // configuration
  logic [13:0] row_bytes_q;
  logic [3:0]  bpp_q;
  logic [CW-1:0] rb_eff;
  logic [PW-1:0] bpp_eff;
  logic [HW-1:0] hist_idx;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= 14'd1;
      bpp_q       <= 4'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        psu_pkg::RegRowBytes:      row_bytes_q <= cfg_i.payload.data;
        psu_pkg::RegBytesPerPixel: bpp_q       <= cfg_i.payload.data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (row_bytes_q == 14'd0) begin
      rb_eff = CW'(1);
    end else if (32'(row_bytes_q) > MAX_ROW_BYTES) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CW'(row_bytes_q);
    end
    priority if (bpp_q == 4'd0) begin
      bpp_eff = PW'(1);
    end else if (32'(bpp_q) > MAX_PIXEL_BYTES) begin
      bpp_eff = PW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = PW'(bpp_q);
    end
    hist_idx = HW'(bpp_eff - PW'(1));
  end

  // front: row position, tracked at input transfer
  logic [CW-1:0]        col_q, col_d;
  psu_pkg::psu_filter_e filt_q, filt_d;
  logic                 first_q, first_d;
  logic                 err_q, err_d;
  logic                 in_xfer;
  item_t                item_d;
  logic [CW-1:0]        x_full;

  // stage
  logic  s1_v_q, s1_fire;
  item_t s1_q;
  logic [7:0] up_rd_q;

  // output register
  logic     out_v_q;
  logic     out_load;
  psu_pkg::psu_out_t out_q;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign in_i.ready  = !s1_v_q || s1_fire;

  always_comb begin
    col_d   = col_q;
    filt_d  = filt_q;
    first_d = first_q;
    err_d   = err_q;
    x_full  = col_q - CW'(1);

    item_d.is_filter = in_i.payload.start_of_image || (col_q == '0);
    item_d.data_byte = in_i.payload.data_byte;
    item_d.x         = x_full[AW-1:0];
    item_d.left_ok   = 32'(x_full) >= 32'(bpp_eff);
    item_d.first_row = first_q;
    item_d.filter    = filt_q;
    item_d.bad       = err_q;
    item_d.last      = col_q >= rb_eff;

    if (item_d.is_filter) begin
      if (in_i.payload.start_of_image) begin
        first_d = 1'b1;
        err_d   = 1'b0;
      end
      if (in_i.payload.data_byte > psu_pkg::MaxFilterCode) begin
        err_d  = 1'b1;
        filt_d = psu_pkg::FILT_NONE;
      end else begin
        filt_d = psu_pkg::psu_filter_e'(in_i.payload.data_byte[2:0]);
      end
      col_d = CW'(1);
    end else if (item_d.last) begin
      col_d   = '0;
      first_d = 1'b0;
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      filt_q  <= psu_pkg::FILT_NONE;
      first_q <= 1'b1;
      err_q   <= 1'b0;
    end else if (in_xfer) begin
      col_q   <= col_d;
      filt_q  <= filt_d;
      first_q <= first_d;
      err_q   <= err_d;
    end
  end

  // prior-row memory: read at input transfer, write as a byte leaves the stage
  logic [7:0] prior_q [MAX_ROW_BYTES];
  logic [7:0] result;

  always_ff @(posedge clk_i) begin
    if (s1_fire && !s1_q.is_filter) begin
      prior_q[s1_q.x] <= result;
    end
    if (in_xfer && !item_d.is_filter) begin
      up_rd_q <= prior_q[item_d.x];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_xfer) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= item_d;
    end
  end

  // reconstruction
  logic [7:0] left_hist_q   [MAX_PIXEL_BYTES];
  logic [7:0] upleft_hist_q [MAX_PIXEL_BYTES];
  psu_pkg::psu_pred_req_t pred_req;
  logic [7:0] pred;

  always_comb begin
    pred_req.filter = s1_q.filter;
    pred_req.left   = s1_q.left_ok ? left_hist_q[hist_idx] : 8'd0;
    pred_req.up     = s1_q.first_row ? 8'd0 : up_rd_q;
    pred_req.upleft = (!s1_q.first_row && s1_q.left_ok) ? upleft_hist_q[hist_idx] : 8'd0;
  end

  psu_predict u_predict (
    .req_i  (pred_req),
    .pred_o (pred)
  );

  assign result   = s1_q.data_byte + pred;
  assign s1_fire  = s1_v_q && (s1_q.is_filter || !out_v_q || out_o.ready);
  assign out_load = s1_fire && !s1_q.is_filter;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist_q[i]   <= 8'd0;
        upleft_hist_q[i] <= 8'd0;
      end
    end else if (out_load) begin
      for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
        left_hist_q[i]   <= left_hist_q[i-1];
        upleft_hist_q[i] <= upleft_hist_q[i-1];
      end
      left_hist_q[0]   <= result;
      upleft_hist_q[0] <= pred_req.up;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.pixel_byte <= result;
      out_q.end_of_row <= s1_q.last;
      out_q.bad_filter <= s1_q.bad;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.payload = out_q;

endmodule

>>> verif/png_scanline_unfilter_top_tb.sv
class pixel_scoreboard;
  localparam int unsigned ROW_LIMIT   = 8192;
  localparam int unsigned PIXEL_LIMIT = 8;

  logic [7:0]  prior_row [ROW_LIMIT];
  logic [7:0]  left_hist [PIXEL_LIMIT];
  logic [7:0]  upleft_hist [PIXEL_LIMIT];
  int unsigned column;
  psu_pkg::psu_filter_e row_filter;
  bit          first_row;
  bit          error_seen;
  int unsigned row_bytes;
  int unsigned bytes_per_pixel;
  int unsigned written_extent;

  psu_pkg::psu_out_t pending_pixels[$];
  int unsigned error_count;
  int unsigned bytes_taken;
  int unsigned pixels_checked;
  int unsigned images_started;
  int unsigned bad_rows;
  int unsigned reg_writes;
  int unsigned rows_by_filter [5];

  function new();
    foreach (left_hist[i]) begin
      left_hist[i]   = 8'h00;
      upleft_hist[i] = 8'h00;
    end
    foreach (rows_by_filter[i]) rows_by_filter[i] = 0;
    column          = 0;
    row_filter      = psu_pkg::FILT_NONE;
    first_row       = 1'b1;
    error_seen      = 1'b0;
    row_bytes       = 1;
    bytes_per_pixel = 1;
    written_extent  = 0;
    error_count     = 0;
    bytes_taken     = 0;
    pixels_checked  = 0;
    images_started  = 0;
    bad_rows        = 0;
    reg_writes      = 0;
  endfunction

  function int unsigned eff_row_bytes();
    if (row_bytes == 0) return 1;
    if (row_bytes > ROW_LIMIT) return ROW_LIMIT;
    return row_bytes;
  endfunction

  function int unsigned eff_bpp();
    if (bytes_per_pixel == 0) return 1;
    if (bytes_per_pixel > PIXEL_LIMIT) return PIXEL_LIMIT;
    return bytes_per_pixel;
  endfunction

  function int unsigned pending_count();
    return pending_pixels.size();
  endfunction

  // True when the next byte, unless it starts an image, would read prior-row
  // entries never written since reset.
  function bit must_restart();
    if (first_row) return 1'b0;
    if (column == 0) return eff_row_bytes() > written_extent;
    return (column - 1) >= written_extent;
  endfunction

  function void write_reg(psu_pkg::psu_cfg_t cfg);
    reg_writes++;
    if (cfg.index == psu_pkg::RegRowBytes) row_bytes = cfg.data;
    else if (cfg.index == psu_pkg::RegBytesPerPixel) bytes_per_pixel = cfg.data[3:0];
  endfunction

  function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int p, pa, pb, pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    return (pb <= pc) ? b : c;
  endfunction

  function void take_stream_byte(psu_pkg::psu_in_t item);
    int unsigned rb, bpp, x;
    logic [7:0]  left, up, upleft, pred, pix;
    bit          last;
    rb  = eff_row_bytes();
    bpp = eff_bpp();
    bytes_taken++;
    if (item.start_of_image || column == 0) begin
      if (item.start_of_image) begin
        first_row  = 1'b1;
        error_seen = 1'b0;
        images_started++;
      end
      if (item.data_byte > psu_pkg::MaxFilterCode) begin
        error_seen = 1'b1;
        row_filter = psu_pkg::FILT_NONE;
        bad_rows++;
      end else begin
        row_filter = psu_pkg::psu_filter_e'(item.data_byte[2:0]);
        rows_by_filter[item.data_byte[2:0]]++;
      end
      column = 1;
      return;
    end
    x = column - 1;
    if (x >= ROW_LIMIT) x = ROW_LIMIT - 1;
    left   = (x >= bpp) ? left_hist[bpp-1] : 8'h00;
    up     = first_row ? 8'h00 : prior_row[x];
    upleft = (!first_row && x >= bpp) ? upleft_hist[bpp-1] : 8'h00;
    case (row_filter)
      psu_pkg::FILT_SUB:   pred = left;
      psu_pkg::FILT_UP:    pred = up;
      psu_pkg::FILT_AVG:   pred = 8'((9'(left) + 9'(up)) >> 1);
      psu_pkg::FILT_PAETH: pred = paeth_pick(left, up, upleft);
      default:             pred = 8'h00;
    endcase
    pix = item.data_byte + pred;
    for (int i = PIXEL_LIMIT - 1; i > 0; i--) begin
      left_hist[i]   = left_hist[i-1];
      upleft_hist[i] = upleft_hist[i-1];
    end
    left_hist[0]   = pix;
    upleft_hist[0] = up;
    prior_row[x]   = pix;
    if (x + 1 > written_extent) written_extent = x + 1;
    last = (x + 1) >= rb;
    if (last) begin
      column    = 0;
      first_row = 1'b0;
    end else begin
      column++;
    end
    pending_pixels.push_back('{pixel_byte: pix, end_of_row: last, bad_filter: error_seen});
  endfunction

  task flag_mismatch(string msg);
    error_count++;
    if (error_count <= 20) $display("mismatch at pixel %0d: %s", pixels_checked, msg);
  endtask

  task check_pixel(psu_pkg::psu_out_t got);
    psu_pkg::psu_out_t want;
    if (pending_pixels.size() == 0) begin
      flag_mismatch($sformatf("unexpected pixel %02h", got.pixel_byte));
      return;
    end
    want = pending_pixels.pop_front();
    if (got.pixel_byte !== want.pixel_byte)
      flag_mismatch($sformatf("pixel_byte %02h, want %02h", got.pixel_byte, want.pixel_byte));
    if (got.end_of_row !== want.end_of_row)
      flag_mismatch($sformatf("end_of_row %b, want %b", got.end_of_row, want.end_of_row));
    if (got.bad_filter !== want.bad_filter)
      flag_mismatch($sformatf("bad_filter %b, want %b", got.bad_filter, want.bad_filter));
    pixels_checked++;
  endtask

  task flag_leftovers();
    if (pending_pixels.size() != 0)
      flag_mismatch($sformatf("%0d pixels never came out", pending_pixels.size()));
  endtask
endclass

module png_scanline_unfilter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psu_stream_if #(.payload_t(psu_pkg::psu_in_t))  in_if ();
  psu_stream_if #(.payload_t(psu_pkg::psu_out_t)) out_if ();
  psu_stream_if #(.payload_t(psu_pkg::psu_cfg_t)) cfg_if ();

  png_scanline_unfilter_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  pixel_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     hold_cycles = 0;
  bit              sender_idles = 1'b1;
  bit              receiver_idles = 1'b1;
  bit              long_hold_req = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && sb != null) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.payload);
      if (in_if.valid && in_if.ready) sb.take_stream_byte(in_if.payload);
      if (out_if.valid && out_if.ready) sb.check_pixel(out_if.payload);
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles == 0 && long_hold_req) begin
      hold_cycles   = 400;
      long_hold_req = 1'b0;
    end else if (hold_cycles == 0 && receiver_idles && $urandom_range(0, 4) == 0) begin
      hold_cycles = $urandom_range(1, 9);
    end
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic psu_pkg::psu_in_t pick_stream_byte();
    psu_pkg::psu_in_t item;
    bit      at_filter;
    at_filter = (sb.column == 0);
    item.start_of_image = sb.must_restart() || ($urandom_range(0, at_filter ? 9 : 60) == 0);
    if (item.start_of_image || at_filter) begin
      if ($urandom_range(0, 11) == 0) item.data_byte = 8'($urandom_range(5, 255));
      else item.data_byte = 8'($urandom_range(0, 4));
    end else if ($urandom_range(0, 7) == 0) begin
      item.data_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      item.data_byte = 8'($urandom);
    end
    return item;
  endfunction

  task automatic send_item(psu_pkg::psu_in_t item, bit pick_random);
    int unsigned gap;
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    if (pick_random) item = pick_stream_byte();
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic push_byte(logic [7:0] value, bit soi);
    send_item('{data_byte: value, start_of_image: soi}, 1'b0);
  endtask

  task automatic push_random(int unsigned count);
    repeat (count) send_item('0, 1'b1);
  endtask

  // Drop valid, wait for all pixels, then allow for filter bytes still in flight.
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [psu_pkg::CfgIdxW-1:0] idx,
                           logic [psu_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: value};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    sb             = new();
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    out_if.ready   = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(psu_pkg::RegRowBytes, 14'd0);
    write_reg(psu_pkg::RegBytesPerPixel, 14'd0);
    push_byte(8'(psu_pkg::FILT_SUB), 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'(psu_pkg::FILT_UP), 1'b0);
    push_byte(8'h00, 1'b0);
    settle();
    write_reg(psu_pkg::RegRowBytes, 14'd3);
    write_reg(psu_pkg::RegBytesPerPixel, 14'd15);
    push_byte(8'(psu_pkg::FILT_NONE), 1'b1);
    push_byte(8'h10, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'(psu_pkg::FILT_AVG), 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'(psu_pkg::FILT_PAETH), 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h05, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'(psu_pkg::FILT_PAETH), 1'b1);
    push_byte(8'h11, 1'b0);
    settle();
    write_reg(psu_pkg::RegRowBytes, 14'd5);
    write_reg(psu_pkg::RegBytesPerPixel, 14'd2);
    push_byte(8'h22, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h7F, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case ($urandom_range(0, 5))
        0:       write_reg(psu_pkg::RegRowBytes, 14'd0);
        1:       write_reg(psu_pkg::RegRowBytes, 14'd1);
        default: write_reg(psu_pkg::RegRowBytes, 14'($urandom_range(2, 20)));
      endcase
      if (ph == 5) write_reg(psu_pkg::RegRowBytes, 14'($urandom_range(100, 300)));
      write_reg(psu_pkg::RegBytesPerPixel, 14'($urandom_range(0, 15)));
      sender_idles   = (ph % 3 != 2);
      receiver_idles = (ph % 3 != 1);
      if (ph == 2) begin
        sender_idles  = 1'b0;
        long_hold_req = 1'b1;
      end
      if (ph == 4) begin
        push_random(30);
        settle();
        push_random(35);
      end else begin
        push_random(65);
      end
    end

    // Back-to-back rows, no idling on either side.
    settle();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    write_reg(psu_pkg::RegRowBytes, 14'($urandom_range(8, 24)));
    write_reg(psu_pkg::RegBytesPerPixel, 14'd8);
    push_random(60);

    settle();
    sb.flag_leftovers();
    $display("covered %0d stream bytes, %0d pixels checked, %0d images, %0d register writes",
             sb.bytes_taken, sb.pixels_checked, sb.images_started, sb.reg_writes);
    $display("rows none/sub/up/avg/paeth %0d/%0d/%0d/%0d/%0d, bad filter rows %0d",
             sb.rows_by_filter[0], sb.rows_by_filter[1], sb.rows_by_filter[2],
             sb.rows_by_filter[3], sb.rows_by_filter[4], sb.bad_rows);
    if (sb.error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
